[hdl/frt_pkg.sv]
// shared types, constants and codes for the firewall rule table
package frt_pkg;

  // table geometry
  localparam int MAX_RULES = 64;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int MATCH_W   = 6;

  // channel widths
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CHECK  = 2'd1,
    OP_DELETE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_REJECTED = 3'd4,
    ST_DELETED  = 3'd5,
    ST_NOTFOUND = 3'd6,
    ST_FLUSHED  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // one stored rule; flags bit 0 address range, bit 1 port range
  typedef struct packed {
    logic [31:0] ip_lo;
    logic [31:0] ip_hi;
    logic [15:0] port_lo;
    logic [15:0] port_hi;
    logic [1:0]  flags;
  } rule_t;

endpackage

[hdl/frt_match.sv]
// per-entry compare: range containment for check, exact identity for delete
module frt_match import frt_pkg::*; (
  input  rule_t entry,
  input  rule_t key,
  input  op_t   op,
  output logic  hit
);

  logic in_range;
  logic same;

  // check uses the low fields of the key as the connection address and port
  assign in_range = (entry.ip_lo <= key.ip_lo) && (key.ip_lo <= entry.ip_hi) &&
                    (entry.port_lo <= key.port_lo) && (key.port_lo <= entry.port_hi);

  // delete needs every bound and both form flags to agree
  assign same = (entry == key);

  assign hit = (op == OP_DELETE) ? same : in_range;

endmodule

[hdl/firewall_rule_table_match.sv]
// top level: ordered first-match address and port rule table
//
// One stream of requests in, one stream of results out. Each input
// transaction carries an opcode (add, check, delete, flush) and a rule or a
// connection; each one yields exactly one result transaction with a status
// code and, for an accepted check, the position of the first matching rule.
// Rules live in a single-port-read, single-port-write table memory of
// MAX_RULES entries with a registered read.
// Add, flush and invalid requests go straight to the done state after
// acceptance. Check and delete read the table one entry per cycle in order;
// a check stops at its first hit or after the last entry. A delete that hits
// then moves every later entry down by one, one entry per cycle.
// One request is worked on at a time; in_tready is high only while idle.
// A finished result waits in an output register while the next request is
// taken; if the receiver stalls, the block holds its next result until the
// output register frees. Reset empties the table and drops any pending
// result; the table memory itself is not cleared.
module firewall_rule_table_match import frt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // ip_low[31:0], ip_high[63:32], port_low[79:64], port_high[95:80]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0], ip_is_range[2], port_is_range[3]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[2:0], match_index[8:3], zero[15:9]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  rule_t            key_r, key_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [MATCH_W-1:0] res_index_r, res_index_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [MATCH_W-1:0] out_index_r, out_index_nxt;

  rule_t            mem [MAX_RULES];
  rule_t            rd_data_r;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rule_t            wr_data;

  op_t              in_op;
  rule_t            in_key;
  logic             in_irng;
  logic             in_prng;
  logic             in_valid_rule;
  logic             in_acc;
  logic             more;
  logic             out_free;
  logic             hit;

  // unpack request and normalize single values
  assign in_op   = op_t'(in_tuser[1:0]);
  assign in_irng = in_tuser[2];
  assign in_prng = in_tuser[3];

  always_comb begin
    in_key.ip_lo   = in_tdata[31:0];
    in_key.ip_hi   = in_irng ? in_tdata[63:32] : in_tdata[31:0];
    in_key.port_lo = in_tdata[79:64];
    in_key.port_hi = in_prng ? in_tdata[95:80] : in_tdata[79:64];
    in_key.flags   = {in_prng, in_irng};
  end

  assign in_valid_rule = (!in_irng || (in_tdata[31:0] < in_tdata[63:32])) &&
                         (!in_prng || (in_tdata[79:64] <= in_tdata[95:80]));

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign more      = (idx_r < count_r);
  assign out_free  = !out_valid_r || out_tready;

  // entry compare on the registered read data
  frt_match u_match (
    .entry (rd_data_r),
    .key   (key_r),
    .op    (op_r),
    .hit   (hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_CHECK || (in_op == OP_DELETE && in_valid_rule)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_r && hit) begin
          state_nxt = (op_r == OP_DELETE) ? S_SHIFT : S_DONE;
        end else if (!rd_vld_r && !more) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!rd_vld_r && !more) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = rd_vld_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_data        = in_key;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_op;
          key_nxt       = in_key;
          idx_nxt       = '0;
          rd_vld_nxt    = 1'b0;
          res_index_nxt = '0;
          unique case (in_op)
            OP_ADD: begin
              if (!in_valid_rule) begin
                res_status_nxt = ST_INVALID;
              end else if (count_r >= CNT_W'(MAX_RULES)) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
                res_status_nxt = ST_ADDED;
              end
            end
            OP_CHECK: begin
              res_status_nxt = ST_REJECTED;
            end
            OP_DELETE: begin
              res_status_nxt = in_valid_rule ? ST_NOTFOUND : ST_INVALID;
            end
            OP_FLUSH: begin
              count_nxt      = '0;
              res_status_nxt = ST_FLUSHED;
            end
            default: res_status_nxt = ST_INVALID;
          endcase
        end
      end
      S_SCAN, S_SHIFT: begin
        // one read a cycle, in table order
        rd_en      = more;
        rd_vld_nxt = more;
        rd_idx_nxt = idx_r[IDX_W-1:0];
        if (more) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (state_r == S_SCAN) begin
          if (rd_vld_r && hit && op_r == OP_CHECK) begin
            res_status_nxt = ST_ACCEPTED;
            res_index_nxt  = MATCH_W'(rd_idx_r);
          end
        end else begin
          // compaction: entry read from j+1 lands at j
          if (rd_vld_r) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_r - IDX_W'(1);
            wr_data = rd_data_r;
          end else if (!more) begin
            count_nxt      = count_r - CNT_W'(1);
            res_status_nxt = ST_DELETED;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // rule table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - MATCH_W - 3){1'b0}}, out_index_r, out_status_r};

endmodule

[hdl/frt_checker.sv]
// port-level checker for the rule table, bound to the top level
module frt_checker import frt_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // match index is zero unless the connection was accepted
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != ST_ACCEPTED) |-> (out_tdata[8:3] == '0))
    else $error("match index set on a non-accepted result");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind firewall_rule_table_match frt_checker u_frt_checker (.*);

[tb/tb.sv]
// testbench for the rule table: directed rows, then random rule traffic checked by a predictor
module tb;
  import frt_pkg::*;

  localparam int ITEMS          = 800;
  localparam int QUIET_TAIL     = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    op_t         op;
    logic [31:0] ip_lo;
    logic [31:0] ip_hi;
    logic        ip_rng;
    logic [15:0] port_lo;
    logic [15:0] port_hi;
    logic        port_rng;
  } request_t;

  typedef struct {
    status_t            status;
    logic [MATCH_W-1:0] index;
  } verdict_t;

  typedef struct {
    request_t req;
    bit       typed;
    verdict_t want;
  } plan_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor copy of the rule table
  rule_t    acl_rules [MAX_RULES];
  int       acl_count = 0;
  verdict_t verdicts_due [$];
  plan_row_t directed_plan [$];

  int mismatches   = 0;
  int sent         = 0;
  int idle_cycles  = 0;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  bit quiet        = 1'b0;
  bit hold_req     = 1'b0;

  firewall_rule_table_match u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor: applies one request to the table copy and returns its verdict
  function automatic verdict_t apply_request(request_t r);
    logic [31:0] ip_top;
    logic [15:0] port_top;
    logic [1:0]  form;
    bit          ok;
    bit          hit;
    int          k;
    int          j;
    verdict_t    v;
    ip_top   = r.ip_rng ? r.ip_hi : r.ip_lo;
    port_top = r.port_rng ? r.port_hi : r.port_lo;
    form     = {r.port_rng, r.ip_rng};
    ok       = (!r.ip_rng || r.ip_lo < r.ip_hi) && (!r.port_rng || r.port_lo <= r.port_hi);
    hit      = 1'b0;
    v.index  = '0;
    case (r.op)
      OP_ADD: begin
        if (!ok) begin
          v.status = ST_INVALID;
        end else if (acl_count >= MAX_RULES) begin
          v.status = ST_FULL;
        end else begin
          acl_rules[acl_count].ip_lo   = r.ip_lo;
          acl_rules[acl_count].ip_hi   = ip_top;
          acl_rules[acl_count].port_lo = r.port_lo;
          acl_rules[acl_count].port_hi = port_top;
          acl_rules[acl_count].flags   = form;
          acl_count++;
          v.status = ST_ADDED;
        end
      end
      OP_CHECK: begin
        // first rule in insertion order wins
        v.status = ST_REJECTED;
        for (k = 0; k < acl_count && !hit; k++) begin
          if (acl_rules[k].ip_lo <= r.ip_lo && r.ip_lo <= acl_rules[k].ip_hi &&
              acl_rules[k].port_lo <= r.port_lo && r.port_lo <= acl_rules[k].port_hi) begin
            hit      = 1'b1;
            v.status = ST_ACCEPTED;
            v.index  = k[MATCH_W-1:0];
          end
        end
      end
      OP_DELETE: begin
        if (!ok) begin
          v.status = ST_INVALID;
        end else begin
          v.status = ST_NOTFOUND;
          for (k = 0; k < acl_count && !hit; k++) begin
            if (acl_rules[k].ip_lo == r.ip_lo && acl_rules[k].ip_hi == ip_top &&
                acl_rules[k].port_lo == r.port_lo && acl_rules[k].port_hi == port_top &&
                acl_rules[k].flags == form) begin
              hit = 1'b1;
              // close the gap
              for (j = k; j + 1 < acl_count; j++) acl_rules[j] = acl_rules[j + 1];
              acl_count--;
              v.status = ST_DELETED;
            end
          end
        end
      end
      default: begin
        acl_count = 0;
        v.status  = ST_FLUSHED;
      end
    endcase
    return v;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // result side: compare each accepted transaction with the oldest verdict
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d index %0d",
                                out_tdata[2:0], out_tdata[8:3]));
      end else begin
        want = verdicts_due.pop_front();
        if (out_tdata[2:0] !== want.status || out_tdata[8:3] !== want.index)
          note_mismatch($sformatf("result mismatch: status exp %0d got %0d, index exp %0d got %0d",
                                  want.status, out_tdata[2:0], want.index, out_tdata[8:3]));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(1, 100) <= rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // random rule, mostly well formed; single values carry garbage upper bounds
  function automatic request_t random_rule(op_t op, bit narrow);
    request_t    r;
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] c;
    logic [15:0] d;
    r.op       = op;
    r.ip_rng   = 1'($urandom_range(0, 1));
    r.port_rng = 1'($urandom_range(0, 1));
    r.ip_lo    = $urandom;
    r.ip_hi    = $urandom;
    r.port_lo  = 16'($urandom);
    r.port_hi  = 16'($urandom);
    if (r.ip_rng) begin
      if (narrow) begin
        r.ip_lo = $urandom_range(0, 32'hFFFF_EFFF);
        r.ip_hi = r.ip_lo + $urandom_range(1, 4096);
      end else begin
        a = $urandom;
        b = $urandom;
        if (a == b) b = ~a;
        r.ip_lo = (a < b) ? a : b;
        r.ip_hi = (a < b) ? b : a;
      end
    end
    if (r.port_rng) begin
      if (narrow) begin
        r.port_lo = 16'($urandom_range(0, 65000));
        r.port_hi = r.port_lo + 16'($urandom_range(0, 500));
      end else begin
        c = 16'($urandom);
        d = 16'($urandom);
        r.port_lo = (c < d) ? c : d;
        r.port_hi = (c < d) ? d : c;
      end
    end
    // occasional malformed range: reversed or empty address, reversed port
    if ($urandom_range(0, 9) == 0) begin
      if (r.ip_rng) begin
        a       = r.ip_lo;
        r.ip_lo = r.ip_hi;
        if ($urandom_range(0, 1)) r.ip_hi = a;
      end else if (r.port_rng && r.port_lo != r.port_hi) begin
        c         = r.port_lo;
        r.port_lo = r.port_hi;
        r.port_hi = c;
      end
    end
    return r;
  endfunction

  // request that copies a stored rule
  function automatic request_t rule_request(op_t op, int k);
    request_t r;
    r.op       = op;
    r.ip_rng   = acl_rules[k].flags[0];
    r.port_rng = acl_rules[k].flags[1];
    r.ip_lo    = acl_rules[k].ip_lo;
    r.ip_hi    = r.ip_rng ? acl_rules[k].ip_hi : $urandom;
    r.port_lo  = acl_rules[k].port_lo;
    r.port_hi  = r.port_rng ? acl_rules[k].port_hi : 16'($urandom);
    return r;
  endfunction

  // value on, inside or just outside a bound
  function automatic logic [31:0] probe_value(logic [31:0] lo, logic [31:0] hi);
    logic [63:0] span;
    logic [63:0] rnd;
    rnd  = {32'd0, $urandom};
    span = {32'd0, hi} - {32'd0, lo} + 64'd1;
    rnd  = rnd % span;
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return hi + 32'd1;
      3: return lo - 32'd1;
      default: return lo + rnd[31:0];
    endcase
  endfunction

  function automatic request_t check_request();
    request_t    r;
    logic [31:0] pt;
    int          k;
    r = random_rule(OP_CHECK, 1'b0);
    if (acl_count > 0 && $urandom_range(0, 9) < 7) begin
      k         = $urandom_range(0, acl_count - 1);
      r.ip_lo   = probe_value(acl_rules[k].ip_lo, acl_rules[k].ip_hi);
      pt        = probe_value({16'd0, acl_rules[k].port_lo}, {16'd0, acl_rules[k].port_hi});
      r.port_lo = pt[15:0];
    end
    return r;
  endfunction

  // weighted mix of operations against the current table
  function automatic request_t next_request(bit narrow);
    request_t r;
    int       p;
    int       add_pct;
    p       = $urandom_range(0, 99);
    add_pct = (acl_count > 40) ? 25 : 45;
    if (p < 3) begin
      r = random_rule(OP_FLUSH, 1'b0);
    end else if (p < 3 + add_pct) begin
      if (acl_count > 0 && $urandom_range(0, 6) == 0)
        r = rule_request(OP_ADD, $urandom_range(0, acl_count - 1));
      else
        r = random_rule(OP_ADD, narrow);
    end else if (p < 75) begin
      r = check_request();
    end else if (acl_count > 0 && $urandom_range(0, 9) < 7) begin
      r = rule_request(OP_DELETE, $urandom_range(0, acl_count - 1));
      // same bounds under another form must not match
      if ($urandom_range(0, 7) == 0) r.ip_rng = ~r.ip_rng;
    end else begin
      r = random_rule(OP_DELETE, narrow);
    end
    return r;
  endfunction

  // one input transaction; the verdict is queued at acceptance
  task automatic send_request(request_t r, bit typed, verdict_t want);
    verdict_t v;
    in_tvalid <= 1'b1;
    in_tdata  <= {r.port_hi, r.port_lo, r.ip_hi, r.ip_lo};
    in_tuser  <= {r.port_rng, r.ip_rng, r.op};
    do @(posedge clk); while (!in_tready);
    v = apply_request(r);
    if (typed) verdicts_due.push_back(want);
    else verdicts_due.push_back(v);
    sent++;
    if (!quiet && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic plan_row(op_t op, logic [31:0] ilo, logic [31:0] ihi, logic irng,
                          logic [15:0] plo, logic [15:0] phi, logic prng,
                          bit typed, status_t st, logic [MATCH_W-1:0] idx);
    plan_row_t row;
    row.req.op       = op;
    row.req.ip_lo    = ilo;
    row.req.ip_hi    = ihi;
    row.req.ip_rng   = irng;
    row.req.port_lo  = plo;
    row.req.port_hi  = phi;
    row.req.port_rng = prng;
    row.typed        = typed;
    row.want.status  = st;
    row.want.index   = idx;
    directed_plan.push_back(row);
  endtask

  // stimulus
  initial begin
    verdict_t none;
    int       i;
    int       kind;
    bit       first_ep;
    bit       hold_done;
    bit       drain_done;
    none.status = ST_ADDED;
    none.index  = '0;
    first_ep    = 1'b1;
    hold_done   = 1'b0;
    drain_done  = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, malformed ranges, bounds at the extremes
    plan_row(OP_CHECK,  32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 1, ST_REJECTED, 0);
    plan_row(OP_DELETE, 32'h0A00_0001, 32'h0, 0, 16'd80, 16'h0, 0, 1, ST_NOTFOUND, 0);
    plan_row(OP_ADD,    32'd5, 32'd5, 1, 16'd1, 16'd1, 0, 1, ST_INVALID, 0);
    plan_row(OP_ADD,    32'hFFFF_FFFF, 32'h0, 1, 16'd1, 16'd1, 0, 1, ST_INVALID, 0);
    plan_row(OP_ADD,    32'd1, 32'd0, 0, 16'd9, 16'd8, 1, 1, ST_INVALID, 0);
    plan_row(OP_ADD,    32'h0, 32'hFFFF_FFFF, 0, 16'h0, 16'hFFFF, 0, 1, ST_ADDED, 0);
    plan_row(OP_ADD,    32'h0, 32'hFFFF_FFFF, 1, 16'h0, 16'hFFFF, 1, 1, ST_ADDED, 0);
    plan_row(OP_ADD,    32'h8000_0000, 32'h0, 0, 16'd443, 16'd443, 1, 1, ST_ADDED, 0);
    plan_row(OP_CHECK,  32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 1, ST_ACCEPTED, 0);
    plan_row(OP_CHECK,  32'hFFFF_FFFF, 32'h0, 0, 16'hFFFF, 16'h0, 0, 1, ST_ACCEPTED, 1);
    plan_row(OP_CHECK,  32'h8000_0000, 32'h0, 0, 16'd443, 16'h0, 0, 1, ST_ACCEPTED, 1);
    // check ignores upper bounds and form flags
    plan_row(OP_CHECK,  32'd7, 32'd3, 1, 16'd1, 16'd0, 1, 0, ST_ADDED, 0);
    // same bounds, other form
    plan_row(OP_DELETE, 32'h0, 32'hFFFF_FFFF, 1, 16'h0, 16'd1234, 0, 0, ST_ADDED, 0);
    plan_row(OP_DELETE, 32'h0, 32'hFFFF_FFFF, 1, 16'h0, 16'hFFFF, 1, 1, ST_DELETED, 0);
    plan_row(OP_CHECK,  32'hFFFF_FFFF, 32'h0, 0, 16'hFFFF, 16'h0, 0, 0, ST_ADDED, 0);
    plan_row(OP_CHECK,  32'h8000_0000, 32'h0, 0, 16'd443, 16'h0, 0, 0, ST_ADDED, 0);
    plan_row(OP_DELETE, 32'd1, 32'd0, 0, 16'd10, 16'd2, 1, 1, ST_INVALID, 0);
    // duplicate rule, delete takes the first copy
    plan_row(OP_ADD,    32'h8000_0000, 32'h0, 0, 16'd443, 16'd443, 1, 1, ST_ADDED, 0);
    plan_row(OP_DELETE, 32'h8000_0000, 32'h0, 0, 16'd443, 16'd443, 1, 1, ST_DELETED, 0);
    plan_row(OP_CHECK,  32'h8000_0000, 32'h0, 0, 16'd443, 16'h0, 0, 0, ST_ADDED, 0);
    plan_row(OP_ADD,    32'hFFFF_FFFE, 32'hFFFF_FFFF, 1, 16'hFFFF, 16'h0, 0, 1, ST_ADDED, 0);
    plan_row(OP_CHECK,  32'hFFFF_FFFF, 32'h0, 0, 16'hFFFF, 16'h0, 0, 0, ST_ADDED, 0);
    plan_row(OP_FLUSH,  32'hDEAD_BEEF, 32'h1234_5678, 1, 16'hAAAA, 16'h5555, 1,
             1, ST_FLUSHED, 0);
    plan_row(OP_CHECK,  32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 1, ST_REJECTED, 0);
    plan_row(OP_DELETE, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 1, ST_NOTFOUND, 0);

    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    for (i = 0; i < directed_plan.size(); i++)
      send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
    wait_drained();

    // random traffic in episodes
    while (sent < ITEMS) begin
      quiet        = (sent >= ITEMS - QUIET_TAIL);
      tx_gap_pct   = $urandom_range(0, 1) ? 30 : 0;
      rx_stall_pct = $urandom_range(0, 1) ? 30 : 0;
      kind         = first_ep ? 0 : $urandom_range(0, 9);
      first_ep     = 1'b0;
      if (kind < 2) begin
        // fill to the top, run into the full table, probe deep entries
        if ($urandom_range(0, 1)) send_request(random_rule(OP_FLUSH, 1'b0), 1'b0, none);
        while (acl_count < MAX_RULES) send_request(random_rule(OP_ADD, 1'b1), 1'b0, none);
        repeat (2) send_request(random_rule(OP_ADD, 1'b1), 1'b0, none);
        repeat (12) send_request(check_request(), 1'b0, none);
      end else if (kind == 2) begin
        // noise: any opcode, unconstrained fields
        repeat (10) send_request(random_rule(op_t'($urandom_range(0, 3)), 1'b0), 1'b0, none);
      end else begin
        repeat ($urandom_range(20, 40))
          send_request(next_request(1'($urandom_range(0, 1))), 1'b0, none);
      end
      if (!hold_done && sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent >= 500) begin
        wait_drained();
        drain_done = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
